// ===== design/pbd_dc_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes, payload types and saturation helper for the
// distance-constraint projection block. No dependencies.
package pbd_dc_pkg;

   localparam int COORD_W     = 32;
   localparam int FRAC_BITS   = 16;
   localparam int INDEX_W     = 20;
   localparam int MASS_W      = 32;
   localparam int STIFF_W     = 17;
   localparam int NAXIS       = 3;
   localparam int NLANE       = 2 * NAXIS;
   localparam int DIFF_W      = COORD_W + 1;
   localparam int WS_W        = MASS_W + 1;
   localparam int SQ_W        = 2 * DIFF_W;
   localparam int LEN_W       = DIFF_W;
   localparam int ERR_W       = LEN_W;
   localparam int KW_W        = STIFF_W + MASS_W;
   localparam int BASE_W      = DIFF_W + ERR_W;
   localparam int NUM_W       = BASE_W + KW_W;
   localparam int DEN_W       = LEN_W + WS_W + FRAC_BITS;
   localparam int QUO_W       = ERR_W;
   localparam int SUM_W       = COORD_W + 3;
   localparam int SPLIT       = 32;
   localparam int BH_W        = BASE_W - SPLIT;
   localparam int KH_W        = KW_W - SPLIT;
   localparam int LL_W        = 2 * SPLIT;
   localparam int LH_W        = BH_W + SPLIT;
   localparam int HL_W        = SPLIT + KH_W;
   localparam int HH_W        = BH_W + KH_W;
   localparam int SQRT_STAGES = LEN_W;
   localparam int DIV_STAGES  = QUO_W;
   localparam int BACK_LAT    = 2 + SQRT_STAGES + 5 + DIV_STAGES + 1;
   localparam int QDEPTH      = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;
   localparam int REQ_BITS    = 2 * INDEX_W + 6 * COORD_W + 3 * MASS_W + STIFF_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int REQ_PAD_W   = REQ_TDATA_W - REQ_BITS;
   localparam int RSP_BITS    = 2 * INDEX_W + 6 * COORD_W + 2;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   localparam logic [STIFF_W-1:0] K_ONE = STIFF_W'(1) << FRAC_BITS;

   localparam logic [1:0] ST_APPLIED    = 2'd0;
   localparam logic [1:0] ST_FIXED      = 2'd1;
   localparam logic [1:0] ST_COINCIDENT = 2'd2;

   typedef logic signed [COORD_W-1:0] coord_type;

   // first field in the lowest bits
   typedef struct packed {
      logic [REQ_PAD_W-1:0] pad;
      logic [STIFF_W-1:0]   stiffness;
      logic [MASS_W-1:0]    rest_length;
      logic [MASS_W-1:0]    inv_mass_b;
      logic [MASS_W-1:0]    inv_mass_a;
      logic [COORD_W-1:0]   bz;
      logic [COORD_W-1:0]   by_coord;
      logic [COORD_W-1:0]   bx;
      logic [COORD_W-1:0]   az;
      logic [COORD_W-1:0]   ay;
      logic [COORD_W-1:0]   ax;
      logic [INDEX_W-1:0]   index_b;
      logic [INDEX_W-1:0]   index_a;
   } req_type;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [1:0]           status;
      logic [COORD_W-1:0]   new_bz;
      logic [COORD_W-1:0]   new_by;
      logic [COORD_W-1:0]   new_bx;
      logic [COORD_W-1:0]   new_az;
      logic [COORD_W-1:0]   new_ay;
      logic [COORD_W-1:0]   new_ax;
      logic [INDEX_W-1:0]   out_index_b;
      logic [INDEX_W-1:0]   out_index_a;
   } rsp_type;

   // classified constraint, front to back
   typedef struct packed {
      logic [INDEX_W-1:0]             idx_a;
      logic [INDEX_W-1:0]             idx_b;
      logic [NAXIS-1:0][COORD_W-1:0]  a;
      logic [NAXIS-1:0][COORD_W-1:0]  b;
      logic [NAXIS-1:0][DIFF_W-1:0]   dmag;
      logic [NAXIS-1:0]               dneg;
      logic [WS_W-1:0]                ws;
      logic [MASS_W-1:0]              rest;
      logic [STIFF_W-1:0]             k;
      logic [MASS_W-1:0]              wa;
      logic [MASS_W-1:0]              wb;
   } job_type;

   typedef struct packed {
      logic [INDEX_W-1:0]             idx_a;
      logic [INDEX_W-1:0]             idx_b;
      logic [NAXIS-1:0][COORD_W-1:0]  a;
      logic [NAXIS-1:0][COORD_W-1:0]  b;
      logic [NAXIS-1:0]               dneg;
      logic                           eneg;
      logic [1:0]                     status;
   } pay_type;

   typedef struct packed {
      pay_type                        pay;
      logic [NAXIS-1:0][DIFF_W-1:0]   dmag;
      logic [WS_W-1:0]                ws;
      logic [MASS_W-1:0]              rest;
      logic [KW_W-1:0]                kwa;
      logic [KW_W-1:0]                kwb;
   } mid_type;

   function automatic coord_type sat_coord(input logic [SUM_W-1:0] v);
      logic [SUM_W-COORD_W:0] top;
      top = v[SUM_W-1:COORD_W-1];
      if (top == '0 || top == '1) begin
         return coord_type'(v[COORD_W-1:0]);
      end else if (v[SUM_W-1]) begin
         return coord_type'({1'b1, {(COORD_W-1){1'b0}}});
      end else begin
         return coord_type'({1'b0, {(COORD_W-1){1'b1}}});
      end
   endfunction

endpackage

// ===== design/pbd_distance_constraint.sv =====
`timescale 1ns / 1ps
// Distance-constraint projection, one constraint per transaction.
// Throughput: one transaction per cycle while the output is not stalled;
// the 33-stage root and 33-stage divider are fully pipelined and a 4-entry
// queue sits ahead of them.
// Reset is synchronous, active high, and clears the valid bits and queue
// pointers; no clearing pass, the block accepts right after reset.
module pbd_distance_constraint (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // index_a, index_b, ax, ay, az, bx, by_coord, bz, inv_mass_a,
   // inv_mass_b, rest_length, stiffness, zero fill
   input  logic [pbd_dc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // out_index_a, out_index_b, new_ax, new_ay, new_az, new_bx, new_by,
   // new_bz, status, zero fill
   output logic [pbd_dc_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import pbd_dc_pkg::*;

   logic    push, q_full, q_empty, q_pop;
   job_type job_f, job_q;
   rsp_type rsp;

   pbd_dc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .q_full     (q_full),
      .job        (job_f)
   );

   pbd_dc_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (job_f),
      .pop   (q_pop),
      .dout  (job_q),
      .full  (q_full),
      .empty (q_empty)
   );

   pbd_dc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job        (job_q),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tdata = rsp;

endmodule

// ===== design/pbd_dc_front.sv =====
`timescale 1ns / 1ps
// Input stage: unpacks a constraint, forms the difference vector, mass sum
// and clamped stiffness, and holds it until the queue takes it. Uses pbd_dc_pkg.
module pbd_dc_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [pbd_dc_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                 push,
   input  logic                                 q_full,
   output pbd_dc_pkg::job_type                  job
);
   import pbd_dc_pkg::*;

   logic    front_v_ff;
   job_type front_ff, front_in;
   logic    load;

   always_comb begin
      req_type                     r;
      logic [NAXIS-1:0][COORD_W-1:0] av;
      logic [NAXIS-1:0][COORD_W-1:0] bv;
      logic [DIFF_W-1:0]           diff;
      r = req_type'(req_tdata);
      av[0] = r.ax;
      av[1] = r.ay;
      av[2] = r.az;
      bv[0] = r.bx;
      bv[1] = r.by_coord;
      bv[2] = r.bz;
      front_in.idx_a = r.index_a;
      front_in.idx_b = r.index_b;
      front_in.a     = av;
      front_in.b     = bv;
      for (int i = 0; i < NAXIS; i++) begin
         diff = DIFF_W'($signed(bv[i])) - DIFF_W'($signed(av[i]));
         front_in.dneg[i] = diff[DIFF_W-1];
         front_in.dmag[i] = diff[DIFF_W-1] ? (~diff + DIFF_W'(1)) : diff;
      end
      front_in.ws   = WS_W'(r.inv_mass_a) + WS_W'(r.inv_mass_b);
      front_in.rest = r.rest_length;
      front_in.k    = (r.stiffness > K_ONE) ? K_ONE : r.stiffness;
      front_in.wa   = r.inv_mass_a;
      front_in.wb   = r.inv_mass_b;
   end

   assign req_tready = !front_v_ff || !q_full;
   assign load       = req_tvalid && req_tready;
   assign push       = front_v_ff && !q_full;
   assign job        = front_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (load) begin
         front_v_ff <= 1'b1;
      end else if (push) begin
         front_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         front_ff <= front_in;
      end
   end

endmodule

// ===== design/pbd_dc_queue.sv =====
`timescale 1ns / 1ps
// Short queue of classified constraints between the input stage and the
// arithmetic pipeline. Uses pbd_dc_pkg.
module pbd_dc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pbd_dc_pkg::job_type   din,
   input  logic                  pop,
   output pbd_dc_pkg::job_type   dout,
   output logic                  full,
   output logic                  empty
);
   import pbd_dc_pkg::*;

   job_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QCNT_W-1:0] cnt_ff;

   assign full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign dout  = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wr_ff <= wr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ff <= rd_ff + QPTR_W'(1);
         end
         if (push && !pop) begin
            cnt_ff <= cnt_ff + QCNT_W'(1);
         end else if (pop && !push) begin
            cnt_ff <= cnt_ff - QCNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

endmodule

// ===== design/pbd_dc_sqrt.sv =====
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, floor result.
// Uses pbd_dc_pkg.
module pbd_dc_sqrt (
   input  logic                         clock,
   input  logic                         en,
   input  logic [pbd_dc_pkg::SQ_W-1:0]  rad,
   output logic [pbd_dc_pkg::LEN_W-1:0] root
);
   import pbd_dc_pkg::*;

   localparam int REM_W = SQ_W + 1;

   logic [REM_W-1:0] rem_ff  [SQRT_STAGES];
   logic [LEN_W-1:0] root_ff [SQRT_STAGES];

   for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stage
      localparam int B = LEN_W - 1 - s;
      logic [REM_W-1:0] rem_i, rem_o, trial;
      logic [LEN_W-1:0] root_i, root_o;

      if (s == 0) begin : g_first
         assign rem_i  = REM_W'(rad);
         assign root_i = '0;
      end else begin : g_next
         assign rem_i  = rem_ff[s-1];
         assign root_i = root_ff[s-1];
      end

      // remainder holds rad - root^2; try setting bit B
      always_comb begin
         trial  = (REM_W'(root_i) << (B + 1)) | (REM_W'(1) << (2 * B));
         rem_o  = rem_i;
         root_o = root_i;
         if (rem_i >= trial) begin
            rem_o     = rem_i - trial;
            root_o[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s]  <= rem_o;
            root_ff[s] <= root_o;
         end
      end
   end

   assign root = root_ff[SQRT_STAGES-1];

endmodule

// ===== design/pbd_dc_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, six lanes over one shared divisor, one
// quotient bit per stage. Uses pbd_dc_pkg.
module pbd_dc_div (
   input  logic                                              clock,
   input  logic                                              en,
   input  logic [pbd_dc_pkg::NLANE-1:0][pbd_dc_pkg::NUM_W-1:0] num,
   input  logic [pbd_dc_pkg::DEN_W-1:0]                      den,
   output logic [pbd_dc_pkg::NLANE-1:0][pbd_dc_pkg::QUO_W-1:0] quo
);
   import pbd_dc_pkg::*;

   logic [NLANE-1:0][DEN_W-1:0] rem_ff [DIV_STAGES];
   logic [NLANE-1:0][QUO_W-1:0] low_ff [DIV_STAGES];
   logic [NLANE-1:0][QUO_W-1:0] quo_ff [DIV_STAGES];
   logic [DEN_W-1:0]            den_ff [DIV_STAGES];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      localparam int B = QUO_W - 1 - s;
      logic [NLANE-1:0][DEN_W-1:0] rem_i, rem_o;
      logic [NLANE-1:0][QUO_W-1:0] low_i, quo_i, quo_o;
      logic [DEN_W-1:0]            den_i;

      if (s == 0) begin : g_first
         always_comb begin
            for (int l = 0; l < NLANE; l++) begin
               rem_i[l] = num[l][NUM_W-1:QUO_W];
               low_i[l] = num[l][QUO_W-1:0];
            end
         end
         assign quo_i = '0;
         assign den_i = den;
      end else begin : g_next
         assign rem_i = rem_ff[s-1];
         assign low_i = low_ff[s-1];
         assign quo_i = quo_ff[s-1];
         assign den_i = den_ff[s-1];
      end

      always_comb begin
         logic [DEN_W:0] trial;
         logic [DEN_W:0] diff;
         for (int l = 0; l < NLANE; l++) begin
            trial    = {rem_i[l], low_i[l][B]};
            diff     = trial - {1'b0, den_i};
            rem_o[l] = trial[DEN_W-1:0];
            quo_o[l] = quo_i[l];
            if (trial >= {1'b0, den_i}) begin
               rem_o[l]    = diff[DEN_W-1:0];
               quo_o[l][B] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= rem_o;
            low_ff[s] <= low_i;
            quo_ff[s] <= quo_o;
            den_ff[s] <= den_i;
         end
      end
   end

   assign quo = quo_ff[DIV_STAGES-1];

endmodule

// ===== design/pbd_dc_back.sv =====
`timescale 1ns / 1ps
// Arithmetic pipeline: length, error, correction quotients and saturated
// write-back. Uses pbd_dc_pkg, pbd_dc_sqrt and pbd_dc_div.
module pbd_dc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pbd_dc_pkg::job_type   job,
   input  logic                  q_empty,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output pbd_dc_pkg::rsp_type   rsp
);
   import pbd_dc_pkg::*;

   logic                en;
   logic [BACK_LAT-1:0] vld_ff, vld_in;

   // the whole pipeline holds while the output register is stalled
   assign en         = !vld_ff[BACK_LAT-1] || rsp_tready;
   assign q_pop      = en && !q_empty;
   assign vld_in     = {vld_ff[BACK_LAT-2:0], q_pop};
   assign rsp_tvalid = vld_ff[BACK_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   // squares and stiffness-mass products
   mid_type                     m1_ff, m1_in;
   logic [NAXIS-1:0][SQ_W-1:0]  sq1_ff, sq1_in;

   always_comb begin
      m1_in.pay.idx_a  = job.idx_a;
      m1_in.pay.idx_b  = job.idx_b;
      m1_in.pay.a      = job.a;
      m1_in.pay.b      = job.b;
      m1_in.pay.dneg   = job.dneg;
      m1_in.pay.eneg   = 1'b0;
      m1_in.pay.status = ST_APPLIED;
      m1_in.dmag       = job.dmag;
      m1_in.ws         = job.ws;
      m1_in.rest       = job.rest;
      m1_in.kwa        = KW_W'(job.k) * KW_W'(job.wa);
      m1_in.kwb        = KW_W'(job.k) * KW_W'(job.wb);
      for (int i = 0; i < NAXIS; i++) begin
         sq1_in[i] = SQ_W'(job.dmag[i]) * SQ_W'(job.dmag[i]);
      end
   end

   // sum of squares
   mid_type          m2_ff;
   logic [SQ_W-1:0]  s2_ff, s2_in;

   assign s2_in = sq1_ff[0] + sq1_ff[1] + sq1_ff[2];

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1_in;
         sq1_ff <= sq1_in;
         m2_ff  <= m1_ff;
         s2_ff  <= s2_in;
      end
   end

   // length, with the sideband delayed to match
   logic [LEN_W-1:0] len;
   mid_type          sdly_ff [SQRT_STAGES];
   mid_type          ms;

   pbd_dc_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (s2_ff),
      .root  (len)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         sdly_ff[0] <= m2_ff;
         for (int s = 1; s < SQRT_STAGES; s++) begin
            sdly_ff[s] <= sdly_ff[s-1];
         end
      end
   end

   assign ms = sdly_ff[SQRT_STAGES-1];

   // error, status and divisor product
   pay_type                       pe_ff, pe_in;
   logic [NAXIS-1:0][DIFF_W-1:0]  dmage_ff;
   logic [ERR_W-1:0]              emag_ff, emag_in;
   logic [LEN_W+WS_W-1:0]         den0_ff, den0_in;
   logic [KW_W-1:0]               kwae_ff, kwbe_ff;

   always_comb begin
      logic [LEN_W-1:0] rest_ext;
      rest_ext = LEN_W'(ms.rest);
      pe_in    = ms.pay;
      pe_in.eneg = (len < rest_ext);
      emag_in  = (len < rest_ext) ? (rest_ext - len) : (len - rest_ext);
      if (ms.ws == '0) begin
         pe_in.status = ST_FIXED;
      end else if (len == '0) begin
         pe_in.status = ST_COINCIDENT;
      end else begin
         pe_in.status = ST_APPLIED;
      end
      den0_in = (LEN_W+WS_W)'(len) * (LEN_W+WS_W)'(ms.ws);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pe_ff    <= pe_in;
         dmage_ff <= ms.dmag;
         emag_ff  <= emag_in;
         den0_ff  <= den0_in;
         kwae_ff  <= ms.kwa;
         kwbe_ff  <= ms.kwb;
      end
   end

   // per-axis |d| * |e|
   pay_type                       pm_ff;
   logic [NAXIS-1:0][BASE_W-1:0]  base_ff, base_in;
   logic [DEN_W-1:0]              denm_ff;
   logic [KW_W-1:0]               kwam_ff, kwbm_ff;

   always_comb begin
      for (int i = 0; i < NAXIS; i++) begin
         base_in[i] = BASE_W'(dmage_ff[i]) * BASE_W'(emag_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pm_ff   <= pe_ff;
         base_ff <= base_in;
         denm_ff <= {den0_ff, {FRAC_BITS{1'b0}}};
         kwam_ff <= kwae_ff;
         kwbm_ff <= kwbe_ff;
      end
   end

   // partial products of the numerators; lanes 0..2 vertex a, 3..5 vertex b
   pay_type                     pp_ff;
   logic [NLANE-1:0][LL_W-1:0]  pll_ff, pll_in;
   logic [NLANE-1:0][LH_W-1:0]  plh_ff, plh_in;
   logic [NLANE-1:0][HL_W-1:0]  phl_ff, phl_in;
   logic [NLANE-1:0][HH_W-1:0]  phh_ff, phh_in;
   logic [DEN_W-1:0]            denp_ff;

   always_comb begin
      logic [BASE_W-1:0] bsel;
      logic [KW_W-1:0]   ksel;
      for (int side = 0; side < 2; side++) begin
         for (int i = 0; i < NAXIS; i++) begin
            bsel = base_ff[i];
            ksel = (side == 0) ? kwam_ff : kwbm_ff;
            pll_in[side*NAXIS+i] = LL_W'(bsel[SPLIT-1:0]) * LL_W'(ksel[SPLIT-1:0]);
            plh_in[side*NAXIS+i] = LH_W'(bsel[BASE_W-1:SPLIT]) * LH_W'(ksel[SPLIT-1:0]);
            phl_in[side*NAXIS+i] = HL_W'(bsel[SPLIT-1:0]) * HL_W'(ksel[KW_W-1:SPLIT]);
            phh_in[side*NAXIS+i] = HH_W'(bsel[BASE_W-1:SPLIT]) * HH_W'(ksel[KW_W-1:SPLIT]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= pm_ff;
         pll_ff  <= pll_in;
         plh_ff  <= plh_in;
         phl_ff  <= phl_in;
         phh_ff  <= phh_in;
         denp_ff <= denm_ff;
      end
   end

   // partial sums, then full numerators
   pay_type                      ps1_ff, ps2_ff;
   logic [NLANE-1:0][NUM_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, num_ff, num_in;
   logic [DEN_W-1:0]             dens1_ff, dens2_ff;

   always_comb begin
      for (int l = 0; l < NLANE; l++) begin
         lo_in[l]  = NUM_W'(pll_ff[l]) + (NUM_W'(plh_ff[l]) << SPLIT);
         hi_in[l]  = NUM_W'(phl_ff[l]) + (NUM_W'(phh_ff[l]) << SPLIT);
         num_in[l] = lo_ff[l] + (hi_ff[l] << SPLIT);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ps1_ff   <= pp_ff;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         dens1_ff <= denp_ff;
         ps2_ff   <= ps1_ff;
         num_ff   <= num_in;
         dens2_ff <= dens1_ff;
      end
   end

   // quotients, with the sideband delayed to match
   logic [NLANE-1:0][QUO_W-1:0] quo;
   pay_type                     ddly_ff [DIV_STAGES];
   pay_type                     pd;

   pbd_dc_div u_div (
      .clock (clock),
      .en    (en),
      .num   (num_ff),
      .den   (dens2_ff),
      .quo   (quo)
   );

   always_ff @(posedge clock) begin
      if (en) begin
         ddly_ff[0] <= ps2_ff;
         for (int s = 1; s < DIV_STAGES; s++) begin
            ddly_ff[s] <= ddly_ff[s-1];
         end
      end
   end

   assign pd = ddly_ff[DIV_STAGES-1];

   // apply signed corrections and saturate
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic [SUM_W-1:0]               ca, cb, sa, sb;
      logic [NAXIS-1:0][COORD_W-1:0]  na, nb;
      for (int i = 0; i < NAXIS; i++) begin
         ca = SUM_W'(quo[i]);
         cb = SUM_W'(quo[NAXIS+i]);
         if (pd.dneg[i] ^ pd.eneg) begin
            ca = -ca;
            cb = -cb;
         end
         sa = {{(SUM_W-COORD_W){pd.a[i][COORD_W-1]}}, pd.a[i]} + ca;
         sb = {{(SUM_W-COORD_W){pd.b[i][COORD_W-1]}}, pd.b[i]} - cb;
         if (pd.status == ST_APPLIED) begin
            na[i] = sat_coord(sa);
            nb[i] = sat_coord(sb);
         end else begin
            na[i] = pd.a[i];
            nb[i] = pd.b[i];
         end
      end
      rsp_in.pad         = '0;
      rsp_in.status      = pd.status;
      rsp_in.new_ax      = na[0];
      rsp_in.new_ay      = na[1];
      rsp_in.new_az      = na[2];
      rsp_in.new_bx      = nb[0];
      rsp_in.new_by      = nb[1];
      rsp_in.new_bz      = nb[2];
      rsp_in.out_index_a = pd.idx_a;
      rsp_in.out_index_b = pd.idx_b;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp = rsp_ff;

endmodule

// ===== tb/pbd_distance_constraint_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the distance-constraint projection block: random and
// directed constraints, predicted in exact integer math. Depends on pbd_dc_pkg.

module pbd_distance_constraint_test;
   import pbd_dc_pkg::*;

   class projection_scoreboard;
      rsp_type pending[$];
      int      mismatches;
      int      unexpected;

      // exact projection of one constraint
      function automatic rsp_type project(req_type r);
         rsp_type             p;
         logic signed [32:0]  diff[3];
         logic [32:0]         dabs[3];
         logic [67:0]         sumsq;
         logic [35:0]         len;
         logic [35:0]         cand;
         logic [32:0]         wsum;
         logic signed [36:0]  err;
         logic [36:0]         eabs;
         logic [16:0]         k;
         logic [255:0]        den;
         logic [255:0]        num;
         logic [255:0]        qa;
         logic [255:0]        qb;
         logic signed [63:0]  ca;
         logic signed [63:0]  cb;
         logic signed [63:0]  va;
         logic signed [63:0]  vb;
         logic signed [31:0]  a[3];
         logic signed [31:0]  b[3];
         bit                  neg;
         p = '0;
         p.out_index_a = r.index_a;
         p.out_index_b = r.index_b;
         a[0] = r.ax; a[1] = r.ay; a[2] = r.az;
         b[0] = r.bx; b[1] = r.by_coord; b[2] = r.bz;
         sumsq = '0;
         for (int i = 0; i < 3; i++) begin
            diff[i] = 33'(b[i]) - 33'(a[i]);
            dabs[i] = diff[i] < 0 ? -diff[i] : diff[i];
            sumsq += 68'(dabs[i]) * 68'(dabs[i]);
         end
         len = '0;
         for (int n = 35; n >= 0; n--) begin
            cand = len | (36'd1 << n);
            if (72'(cand) * 72'(cand) <= 72'(sumsq)) len = cand;
         end
         k = r.stiffness > K_ONE ? K_ONE : r.stiffness;
         wsum = 33'(r.inv_mass_a) + 33'(r.inv_mass_b);
         p.new_ax = a[0]; p.new_ay = a[1]; p.new_az = a[2];
         p.new_bx = b[0]; p.new_by = b[1]; p.new_bz = b[2];
         if (wsum == 0) begin
            p.status = ST_FIXED;
         end else if (len == 0) begin
            p.status = ST_COINCIDENT;
         end else begin
            p.status = ST_APPLIED;
            err = 37'(len) - 37'(r.rest_length);
            eabs = err < 0 ? -err : err;
            den = (256'(len) * 256'(wsum)) << FRAC_BITS;
            for (int i = 0; i < 3; i++) begin
               neg = diff[i] < 0 ? (err >= 0) : (err < 0);
               num = 256'(dabs[i]) * 256'(eabs) * 256'(k);
               qa = (num * 256'(r.inv_mass_a)) / den;
               qb = (num * 256'(r.inv_mass_b)) / den;
               ca = qa > (256'd1 << 40) ? (64'sd1 <<< 40) : 64'(qa);
               cb = qb > (256'd1 << 40) ? (64'sd1 <<< 40) : 64'(qb);
               if (neg) begin
                  ca = -ca;
                  cb = -cb;
               end
               va = 64'(a[i]) + ca;
               vb = 64'(b[i]) - cb;
               va = va > 64'sd2147483647 ? 64'sd2147483647 :
                    va < -64'sd2147483648 ? -64'sd2147483648 : va;
               vb = vb > 64'sd2147483647 ? 64'sd2147483647 :
                    vb < -64'sd2147483648 ? -64'sd2147483648 : vb;
               a[i] = 32'(va);
               b[i] = 32'(vb);
            end
            p.new_ax = a[0]; p.new_ay = a[1]; p.new_az = a[2];
            p.new_bx = b[0]; p.new_by = b[1]; p.new_bz = b[2];
         end
         return p;
      endfunction

      function void note_request(req_type r);
         pending.push_back(project(r));
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp_r;
         if (pending.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected response %h", got);
            return;
         end
         exp_r = pending.pop_front();
         if (got.out_index_a !== exp_r.out_index_a || got.out_index_b !== exp_r.out_index_b ||
             got.new_ax !== exp_r.new_ax || got.new_ay !== exp_r.new_ay ||
             got.new_az !== exp_r.new_az || got.new_bx !== exp_r.new_bx ||
             got.new_by !== exp_r.new_by || got.new_bz !== exp_r.new_bz ||
             got.status !== exp_r.status || got.pad !== '0) begin
            mismatches++;
            if (mismatches + unexpected <= 10) begin
               $display("mismatch idx %h/%h st %0d/%0d", exp_r.out_index_a, got.out_index_a,
                        exp_r.status, got.status);
               $display("  a exp %h %h %h got %h %h %h", exp_r.new_ax, exp_r.new_ay,
                        exp_r.new_az, got.new_ax, got.new_ay, got.new_az);
               $display("  b exp %h %h %h got %h %h %h", exp_r.new_bx, exp_r.new_by,
                        exp_r.new_bz, got.new_bx, got.new_by, got.new_bz);
            end
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   projection_scoreboard board;
   int  send_idle_pct;
   int  recv_stall_pct;
   bit  stimulus_done;

   pbd_distance_constraint u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: stall at random, check every accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_type'(rsp_tdata));
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7FFF_FFFF - $urandom_range(3);
         2: return $urandom;
         default: return 32'($signed($urandom_range(40000000)) - 20000000);
      endcase
   endfunction

   function automatic req_type random_req();
      req_type r;
      r = '0;
      r.index_a = 20'($urandom);
      r.index_b = 20'($urandom);
      r.ax = pick_coord(); r.ay = pick_coord(); r.az = pick_coord();
      if ($urandom_range(9) == 0) begin
         r.bx = r.ax; r.by_coord = r.ay; r.bz = r.az;
      end else begin
         r.bx = pick_coord(); r.by_coord = pick_coord(); r.bz = pick_coord();
      end
      r.inv_mass_a = $urandom_range(7) == 0 ? 32'd0 :
                     ($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000));
      r.inv_mass_b = $urandom_range(7) == 0 ? 32'd0 :
                     ($urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000));
      r.rest_length = $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h1000000);
      r.stiffness = $urandom_range(4) == 0 ? 17'($urandom) : 17'($urandom_range(65536));
      return r;
   endfunction

   // drop valid only while idling, so back-to-back sends keep it high
   task automatic send(req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(r);
   endtask

   task automatic directed();
      req_type r;
      r = '0;
      send(r);                                   // everything zero: both masses fixed
      r.index_a = '1; r.index_b = 20'h5A5A5;
      r.bx = 32'h0003_0000; r.by_coord = 32'h0004_0000;
      r.inv_mass_a = 32'h1_0000; r.inv_mass_b = 32'h1_0000;
      r.rest_length = 32'h0002_0000; r.stiffness = 17'h10000;
      send(r);                                   // stretched, pulled together
      r.rest_length = 32'h000A_0000;
      send(r);                                   // compressed, pushed apart
      r.inv_mass_a = '0;
      send(r);                                   // a fixed
      r.inv_mass_a = 32'h1_0000; r.inv_mass_b = '0;
      send(r);                                   // b fixed
      r.stiffness = 17'h1FFFF; r.inv_mass_b = '1; r.inv_mass_a = '1;
      send(r);                                   // stiffness clamps to one
      r.stiffness = '0;
      send(r);
      r.bx = r.ax; r.by_coord = r.ay; r.bz = r.az;
      r.stiffness = 17'h8000;
      send(r);                                   // coincident points
      r.ax = 32'h8000_0000; r.ay = 32'h8000_0000; r.az = 32'h8000_0000;
      r.bx = 32'h7FFF_FFFF; r.by_coord = 32'h7FFF_FFFF; r.bz = 32'h7FFF_FFFF;
      r.rest_length = '1; r.inv_mass_a = '1; r.inv_mass_b = 32'd1;
      send(r);                                   // extreme span, saturation
      r.rest_length = '0;
      send(r);
      r.ax = 32'h7FFF_FFFF; r.bx = 32'h8000_0000;
      r.ay = 32'h7FFF_FFFF; r.by_coord = 32'h8000_0000;
      send(r);
      r.rest_length = 32'hFFFF_0000; r.inv_mass_a = 32'd1; r.inv_mass_b = '1;
      r.stiffness = 17'h10000;
      send(r);
   endtask

   initial begin
      int  pct[4][2];
      pct = '{'{0, 0}, '{88, 0}, '{0, 88}, '{8, 8}};
      board = new();
      stimulus_done = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      directed();
      for (int ph = 0; ph < 5; ph++) begin
         send_idle_pct  = pct[ph % 4][0];
         recv_stall_pct = pct[ph % 4][1];
         for (int i = 0; i < 130; i++) send(random_req());
      end
      req_tvalid <= 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (BACK_LAT + 20) @(posedge clock);
      if (board.mismatches == 0 && board.unexpected == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
